// ----- sv/mel_pkg.sv -----
// ----------------------------------------------------------------------------
// mel_pkg: shared types and constants for the median / EMA level classifier
// Window geometry, field widths, register indexes, controller states and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package mel_pkg;

  // Ring of recent valid samples
  localparam int WIN_DEPTH = 8;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int VAL_W      = 13;
  localparam int GAIN_W     = 8;
  localparam int BAND_W     = 8;
  localparam int OFS_W      = 10;
  localparam int AVG_W      = 24;
  localparam int ADJ_W      = 14;
  localparam int LEVEL_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_OFFSET = 3'd6;

  // Classification codes
  typedef enum logic [LEVEL_W-1:0] {
    LEVEL_GREEN  = 2'd0,
    LEVEL_YELLOW = 2'd1,
    LEVEL_RED    = 2'd2
  } level_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MED,
    ST_MUL,
    ST_UPD,
    ST_CLS,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic med_ld;
    logic mul_ld;
    logic avg_ld;
    logic lvl_ld;
    logic out_ld;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_ok;
    logic scan_last;
  } sts_t;

endpackage

// ----- sv/mel_ctrl.sv -----
// ----------------------------------------------------------------------------
// mel_ctrl: sequencer for the median / EMA level classifier
// Walks one word through window scan, median, EMA multiply and update,
// classification and the output register (a rejected word skips to the last), and owns the output valid flag.
// ----------------------------------------------------------------------------
module mel_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mel_pkg::sts_t sts,
  output mel_pkg::cmd_t cmd
);

  mel_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mel_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_ok ? mel_pkg::ST_SCAN : mel_pkg::ST_FIN;
        end
      end
      mel_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = mel_pkg::ST_MED;
        end
      end
      mel_pkg::ST_MED: state_nxt = mel_pkg::ST_MUL;
      mel_pkg::ST_MUL: state_nxt = mel_pkg::ST_UPD;
      mel_pkg::ST_UPD: state_nxt = mel_pkg::ST_CLS;
      mel_pkg::ST_CLS: state_nxt = mel_pkg::ST_FIN;
      mel_pkg::ST_FIN: begin
        if (slot_free) begin
          state_nxt = mel_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mel_pkg::ST_IDLE;
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mel_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mel_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      mel_pkg::ST_MED:  cmd.med_ld    = 1'b1;
      mel_pkg::ST_MUL:  cmd.mul_ld    = 1'b1;
      mel_pkg::ST_UPD:  cmd.avg_ld    = 1'b1;
      mel_pkg::ST_CLS:  cmd.lvl_ld    = 1'b1;
      mel_pkg::ST_FIN:  cmd.out_ld    = slot_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mel_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/mel_dp.sv -----
// ----------------------------------------------------------------------------
// mel_dp: datapath for the median / EMA level classifier
// Holds the configuration registers, the sample ring, the rank scan that
// picks the middle values, the EMA accumulator, the level and the output word.
// ----------------------------------------------------------------------------
module mel_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [mel_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mel_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [mel_pkg::SAMPLE_W-1:0] in_raw_sample,
  input  mel_pkg::cmd_t                       cmd,
  output mel_pkg::sts_t                       sts,
  output logic                                out_accepted,
  output logic [mel_pkg::VAL_W-1:0]           out_smoothed,
  output logic [mel_pkg::ADJ_W-1:0]           out_adjusted,
  output logic [mel_pkg::LEVEL_W-1:0]         out_level
);

  localparam int VW = mel_pkg::VAL_W;
  localparam int PW = mel_pkg::GAIN_W + 1 + mel_pkg::SAMPLE_W + 1;
  localparam int EW = mel_pkg::AVG_W + 3;
  localparam int CW = VW + 2;

  // Configuration registers
  logic [VW-1:0]                     vmin_r, vmax_r, warn_r, alarm_r;
  logic [mel_pkg::GAIN_W-1:0]        gain_r;
  logic [mel_pkg::BAND_W-1:0]        band_r;
  logic signed [mel_pkg::OFS_W-1:0]  ofs_r;

  // Sample ring and scan
  logic [VW-1:0]                     win_r [mel_pkg::WIN_DEPTH];
  logic [mel_pkg::WIN_AW-1:0]        wp_r, idx_r;
  logic [mel_pkg::CNT_W-1:0]         fill_r;
  logic [mel_pkg::CNT_W-1:0]         lt_cnt, le_cnt, k1, k2;
  logic [VW-1:0]                     cand;
  logic [VW-1:0]                     m1_r, m2_r, med_r;
  logic [VW:0]                       med_sum;

  // EMA
  logic [mel_pkg::AVG_W-1:0]         avg_r;
  logic signed [mel_pkg::SAMPLE_W:0] diff;
  logic signed [PW-1:0]              prod, prod_r;
  logic signed [EW-1:0]              ema_sum;
  logic [VW-1:0]                     smooth;
  mel_pkg::level_t                   lvl_r;
  logic                              acc_r;
  logic signed [CW-1:0]              adj;

  // Output word
  logic                              o_acc_r;
  logic [VW-1:0]                     o_smooth_r;
  logic [mel_pkg::ADJ_W-1:0]         o_adj_r;
  logic [mel_pkg::LEVEL_W-1:0]       o_lvl_r;

  // Three-band classifier with hysteresis, compared in signed arithmetic
  function automatic mel_pkg::level_t classify(
    input mel_pkg::level_t             cur,
    input logic [VW-1:0]               s,
    input logic [VW-1:0]               w,
    input logic [VW-1:0]               a,
    input logic [mel_pkg::BAND_W-1:0]  b
  );
    logic signed [CW-1:0] s_x, w_hi, w_lo, a_hi, a_lo;
    mel_pkg::level_t      res;
    s_x  = $signed({2'b00, s});
    w_hi = $signed({2'b00, w}) + $signed({{(CW-mel_pkg::BAND_W){1'b0}}, b});
    w_lo = $signed({2'b00, w}) - $signed({{(CW-mel_pkg::BAND_W){1'b0}}, b});
    a_hi = $signed({2'b00, a}) + $signed({{(CW-mel_pkg::BAND_W){1'b0}}, b});
    a_lo = $signed({2'b00, a}) - $signed({{(CW-mel_pkg::BAND_W){1'b0}}, b});
    case (cur)
      mel_pkg::LEVEL_YELLOW: begin
        if (s_x > a_hi)      res = mel_pkg::LEVEL_RED;
        else if (s_x < w_lo) res = mel_pkg::LEVEL_GREEN;
        else                 res = mel_pkg::LEVEL_YELLOW;
      end
      mel_pkg::LEVEL_RED: begin
        if (s_x < w_lo)      res = mel_pkg::LEVEL_GREEN;
        else if (s_x < a_lo) res = mel_pkg::LEVEL_YELLOW;
        else                 res = mel_pkg::LEVEL_RED;
      end
      default: begin
        if (s_x > a_hi)      res = mel_pkg::LEVEL_RED;
        else if (s_x > w_hi) res = mel_pkg::LEVEL_YELLOW;
        else                 res = mel_pkg::LEVEL_GREEN;
      end
    endcase
    return res;
  endfunction

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmin_r  <= VW'(100);
      vmax_r  <= VW'(5000);
      gain_r  <= mel_pkg::GAIN_W'(64);
      warn_r  <= VW'(800);
      alarm_r <= VW'(1000);
      band_r  <= mel_pkg::BAND_W'(25);
      ofs_r   <= mel_pkg::OFS_W'(180);
    end else if (cfg_valid) begin
      case (cfg_index)
        mel_pkg::CFG_VALID_MIN:   vmin_r  <= cfg_data[VW-1:0];
        mel_pkg::CFG_VALID_MAX:   vmax_r  <= cfg_data[VW-1:0];
        mel_pkg::CFG_EMA_GAIN:    gain_r  <= cfg_data[mel_pkg::GAIN_W-1:0];
        mel_pkg::CFG_WARN_LEVEL:  warn_r  <= cfg_data[VW-1:0];
        mel_pkg::CFG_ALARM_LEVEL: alarm_r <= cfg_data[VW-1:0];
        mel_pkg::CFG_BAND:        band_r  <= cfg_data[mel_pkg::BAND_W-1:0];
        mel_pkg::CFG_USER_OFFSET: ofs_r   <= $signed(cfg_data[mel_pkg::OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // Valid window test on the incoming word
  assign sts.in_ok =
    (in_raw_sample >= $signed({{(mel_pkg::SAMPLE_W-VW){1'b0}}, vmin_r})) &&
    (in_raw_sample <= $signed({{(mel_pkg::SAMPLE_W-VW){1'b0}}, vmax_r}));

  // Rank of the current candidate among the filled entries
  assign cand = win_r[idx_r];

  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < mel_pkg::WIN_DEPTH; j++) begin
      if (mel_pkg::CNT_W'(j) < fill_r) begin
        if (win_r[j] < cand)  lt_cnt = lt_cnt + mel_pkg::CNT_W'(1);
        if (win_r[j] <= cand) le_cnt = le_cnt + mel_pkg::CNT_W'(1);
      end
    end
  end

  // Middle ranks: equal for an odd count, adjacent for an even one
  assign k2 = fill_r >> 1;
  assign k1 = fill_r[0] ? k2 : k2 - mel_pkg::CNT_W'(1);

  assign sts.scan_last =
    ((mel_pkg::CNT_W'(idx_r) + mel_pkg::CNT_W'(1)) == fill_r);

  // Ring write on accept, then one candidate per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      idx_r  <= '0;
    end else if (cmd.accept) begin
      idx_r <= '0;
      if (sts.in_ok) begin
        wp_r <= (wp_r == mel_pkg::WIN_AW'(mel_pkg::WIN_DEPTH - 1))
                ? '0 : wp_r + mel_pkg::WIN_AW'(1);
        if (fill_r != mel_pkg::CNT_W'(mel_pkg::WIN_DEPTH)) begin
          fill_r <= fill_r + mel_pkg::CNT_W'(1);
        end
      end
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + mel_pkg::WIN_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.in_ok) begin
      win_r[wp_r] <= in_raw_sample[VW-1:0];
    end
  end

  // Capture the middle values
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (lt_cnt <= k1 && k1 < le_cnt) m1_r <= cand;
      if (lt_cnt <= k2 && k2 < le_cnt) m2_r <= cand;
    end
  end

  // Median, truncating average for an even count
  assign med_sum = {1'b0, m1_r} + {1'b0, m2_r};

  always_ff @(posedge clk) begin
    if (cmd.med_ld) begin
      med_r <= med_sum[VW:1];
    end
  end

  // EMA step: gain times (median minus average / 256)
  assign diff = $signed({{(mel_pkg::SAMPLE_W+1-VW){1'b0}}, med_r})
              - $signed({1'b0, avg_r[mel_pkg::AVG_W-1:8]});
  assign prod = PW'($signed({1'b0, gain_r})) * PW'(diff);

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      prod_r <= prod;
    end
  end

  assign ema_sum = $signed({3'b000, avg_r}) + EW'(prod_r);

  // Seed on an empty average, else add and clamp to the accumulator range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (cmd.avg_ld) begin
      if (avg_r == '0) begin
        avg_r <= {{(mel_pkg::AVG_W-VW-8){1'b0}}, med_r, 8'h00};
      end else if (ema_sum < 0) begin
        avg_r <= '0;
      end else if (ema_sum[EW-1:mel_pkg::AVG_W] != '0) begin
        avg_r <= '1;
      end else begin
        avg_r <= ema_sum[mel_pkg::AVG_W-1:0];
      end
    end
  end

  assign smooth = avg_r[VW+7:8];

  // Level and accepted flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= mel_pkg::LEVEL_GREEN;
    end else if (cmd.lvl_ld) begin
      lvl_r <= classify(lvl_r, smooth, warn_r, alarm_r, band_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_r <= sts.in_ok;
    end
  end

  // Adjusted value, clamped at zero
  assign adj = $signed({2'b00, smooth}) + CW'(ofs_r);

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      o_acc_r    <= acc_r;
      o_smooth_r <= smooth;
      o_adj_r    <= (adj < 0) ? '0 : adj[mel_pkg::ADJ_W-1:0];
      o_lvl_r    <= lvl_r;
    end
  end

  assign out_accepted = o_acc_r;
  assign out_smoothed = o_smooth_r;
  assign out_adjusted = o_adj_r;
  assign out_level    = o_lvl_r;

endmodule

// ----- sv/median_ema_level_classifier.sv -----
// ----------------------------------------------------------------------------
// median_ema_level_classifier: median filter, EMA and three-level classifier
// Raw samples inside the valid window enter an 8-entry ring; the median of
// the filled entries drives an EMA at scale 256 and a hysteresis classifier.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    in_raw_sample
//   out_      output     out_valid / out_ready  accepted, smoothed, adjusted, level
//   cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A valid word passes the rank scan, which visits one ring entry per cycle,
// then the median, multiply, update and classify states to the output register.
// A rejected word skips the scan and EMA states and goes straight to the last state.
// The sequencer returns to idle before the next word is taken.
// One word is in work at a time; the next is taken while a result waits.
// A stalled output holds the finished word in the sequencer's last state.
// Synchronous reset restores the register defaults and an empty ring.
// ----------------------------------------------------------------------------
module median_ema_level_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mel_pkg::SAMPLE_W-1:0] in_raw_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_accepted,
  output logic [mel_pkg::VAL_W-1:0]           out_smoothed,
  output logic [mel_pkg::ADJ_W-1:0]           out_adjusted,
  output logic [mel_pkg::LEVEL_W-1:0]         out_level,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mel_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mel_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mel_pkg::cmd_t cmd;
  mel_pkg::sts_t sts;

  // Register writes never stall
  assign cfg_ready = 1'b1;

  mel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mel_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_raw_sample (in_raw_sample),
    .cmd           (cmd),
    .sts           (sts),
    .out_accepted  (out_accepted),
    .out_smoothed  (out_smoothed),
    .out_adjusted  (out_adjusted),
    .out_level     (out_level)
  );

endmodule

// ----- sv/mel_checker.sv -----
// ----------------------------------------------------------------------------
// mel_checker: port-level checks for the median / EMA level classifier
// Watches the top-level ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
module mel_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_accepted,
  input logic [mel_pkg::VAL_W-1:0]           out_smoothed,
  input logic [mel_pkg::ADJ_W-1:0]           out_adjusted,
  input logic [mel_pkg::LEVEL_W-1:0]         out_level
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
    $stable(out_smoothed) && $stable(out_adjusted) && $stable(out_level))
    else $error("result word changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One word in work at a time: busy after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  // Only green, yellow and red appear
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= mel_pkg::LEVEL_RED)
    else $error("undefined level code");

  // Adjusted stays at or below the largest smoothed value plus the largest offset
  a_adj: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_adjusted < 14'd8703)
    else $error("adjusted value out of range");

endmodule

bind median_ema_level_classifier mel_checker u_mel_checker (.*);
